// File: rtl/acs_pkg.sv
// shared constants, types and helpers for the activity sequence score pipeline
package acs_pkg;

  localparam int SEQ_W      = 64;
  localparam int LEN_W      = 7;
  localparam int CNT_W      = 7;
  localparam int DIV_W      = 10;
  localparam int Q_W        = 16;
  localparam int CHUNK_W    = 8;
  localparam int NUM_CHUNK  = SEQ_W / CHUNK_W;
  localparam int PART_W     = 4;
  localparam int DIV_STAGES = 4;
  localparam int DIV_STEPS  = Q_W / DIV_STAGES;
  localparam int LAT        = 5 + DIV_STAGES;

  localparam logic [Q_W-1:0] ONE_Q15 = 16'h8000;

  // bit vectors that get counted
  localparam int V_BOTH   = 0;
  localparam int V_EITHER = 1;
  localparam int V_ACT_F  = 2;
  localparam int V_AHIT_F = 3;
  localparam int V_IHIT_F = 4;
  localparam int V_ACT_B  = 5;
  localparam int V_AHIT_B = 6;
  localparam int V_IHIT_B = 7;
  localparam int V_EDGE_F = 8;
  localparam int V_RESP_F = 9;
  localparam int V_EDGE_B = 10;
  localparam int V_RESP_B = 11;
  localparam int V_ONES_A = 12;
  localparam int V_ONES_B = 13;
  localparam int V_C2_F   = 14;
  localparam int V_C3_F   = 15;
  localparam int V_C2_B   = 16;
  localparam int V_C3_B   = 17;
  localparam int NUM_VEC  = 18;

  // divider lanes
  localparam int D_OVL    = 0;
  localparam int D_LAGA_F = 1;
  localparam int D_LAGI_F = 2;
  localparam int D_LAGA_B = 3;
  localparam int D_LAGI_B = 4;
  localparam int D_RESP_F = 5;
  localparam int D_RESP_B = 6;
  localparam int D_BASE_A = 7;
  localparam int D_BASE_B = 8;
  localparam int D_EXC_F  = 9;
  localparam int D_EXC_B  = 10;
  localparam int NUM_DIV  = 11;

  typedef logic [SEQ_W-1:0]                  vec_t;
  typedef logic [LEN_W-1:0]                  len_t;
  typedef logic [Q_W-1:0]                    q_t;
  typedef logic [NUM_VEC-1:0][SEQ_W-1:0]     vec_arr_t;
  typedef logic [NUM_VEC-1:0][CNT_W-1:0]     cnt_arr_t;
  typedef logic [NUM_DIV-1:0][DIV_W-1:0]     div_arr_t;
  typedef logic [NUM_DIV-1:0][Q_W-1:0]       q_arr_t;

  function automatic q_t sat_sub(input q_t x, input q_t y);
    return (x > y) ? q_t'(x - y) : '0;
  endfunction

endpackage

// File: rtl/acs_features.sv
// length saturation, slot masks and the derived bit vectors, one register stage
module acs_features #(
  parameter int SEQ_BITS = 64
) (
  input  logic             clk,
  input  acs_pkg::vec_t    seq_a,
  input  acs_pkg::vec_t    seq_b,
  input  acs_pkg::len_t    seq_len,
  output acs_pkg::vec_arr_t vec_r,
  output acs_pkg::len_t    len_r
);
  import acs_pkg::*;

  localparam int   LEN_MAX = (1 << LEN_W) - 1;
  localparam int   NCAP    = (SEQ_BITS > LEN_MAX) ? LEN_MAX : SEQ_BITS;
  localparam len_t NCAP_V  = LEN_W'(NCAP);

  len_t     n, n_m1;
  vec_t     m, m1, va, vb, ea, eb;
  vec_arr_t vec_nxt;

  always_comb begin
    n    = (seq_len > NCAP_V) ? NCAP_V : seq_len;
    n_m1 = (n == '0) ? '0 : len_t'(n - 1'b1);
    m    = ~({SEQ_W{1'b1}} << n);
    m1   = ~({SEQ_W{1'b1}} << n_m1);
    va   = seq_a & m;
    vb   = seq_b & m;
    // rising edges: active with the previous slot idle
    ea   = va & ~(va << 1);
    eb   = vb & ~(vb << 1);

    vec_nxt           = '0;
    vec_nxt[V_BOTH]   = va & vb;
    vec_nxt[V_EITHER] = va | vb;
    vec_nxt[V_ACT_F]  = va & m1;
    vec_nxt[V_AHIT_F] = va & (vb >> 1);
    vec_nxt[V_IHIT_F] = ~va & m1 & (vb >> 1);
    vec_nxt[V_ACT_B]  = vb & m1;
    vec_nxt[V_AHIT_B] = vb & (va >> 1);
    vec_nxt[V_IHIT_B] = ~vb & m1 & (va >> 1);
    vec_nxt[V_EDGE_F] = ea;
    vec_nxt[V_RESP_F] = ea & ((vb >> 1) | (vb >> 2));
    vec_nxt[V_EDGE_B] = eb;
    vec_nxt[V_RESP_B] = eb & ((va >> 1) | (va >> 2));
    vec_nxt[V_ONES_A] = va;
    vec_nxt[V_ONES_B] = vb;
    vec_nxt[V_C2_F]   = va & (vb >> 2);
    vec_nxt[V_C3_F]   = va & (vb >> 3);
    vec_nxt[V_C2_B]   = vb & (va >> 2);
    vec_nxt[V_C3_B]   = vb & (va >> 3);
  end

  always_ff @(posedge clk) begin
    vec_r <= vec_nxt;
    len_r <= n;
  end

endmodule

// File: rtl/acs_popcnt.sv
// two-stage population count: per-chunk counts, then chunk sum
module acs_popcnt (
  input  logic              clk,
  input  acs_pkg::vec_arr_t vec,
  output acs_pkg::cnt_arr_t cnt_r
);
  import acs_pkg::*;

  logic [NUM_VEC-1:0][NUM_CHUNK-1:0][PART_W-1:0] part_r, part_nxt;
  cnt_arr_t cnt_nxt;

  always_comb begin
    for (int v = 0; v < NUM_VEC; v++) begin
      for (int c = 0; c < NUM_CHUNK; c++) begin
        part_nxt[v][c] = '0;
        for (int b = 0; b < CHUNK_W; b++) begin
          part_nxt[v][c] = part_nxt[v][c] + PART_W'(vec[v][c*CHUNK_W+b]);
        end
      end
    end
  end

  always_comb begin
    for (int v = 0; v < NUM_VEC; v++) begin
      cnt_nxt[v] = '0;
      for (int c = 0; c < NUM_CHUNK; c++) begin
        cnt_nxt[v] = cnt_nxt[v] + CNT_W'(part_r[v][c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    part_r <= part_nxt;
    cnt_r  <= cnt_nxt;
  end

endmodule

// File: rtl/acs_div.sv
// pipelined restoring divider giving floor(32768 * num / den), num <= den, zero on den == 0
module acs_div (
  input  logic                        clk,
  input  logic [acs_pkg::DIV_W-1:0]   num,
  input  logic [acs_pkg::DIV_W-1:0]   den,
  output acs_pkg::q_t                 q
);
  import acs_pkg::*;

  typedef struct packed {
    logic [DIV_W:0]   rem;
    logic [DIV_W-1:0] den;
    q_t               quo;
    logic             zero;
  } div_st_t;

  div_st_t st_r   [DIV_STAGES];
  div_st_t st_nxt [DIV_STAGES];
  div_st_t st_in;

  function automatic div_st_t div_steps(input div_st_t s, input logic first);
    div_st_t t;
    logic    qb;
    t = s;
    for (int k = 0; k < DIV_STEPS; k++) begin
      if (!(first && (k == 0))) t.rem = {t.rem[DIV_W-1:0], 1'b0};
      qb = (t.rem >= {1'b0, t.den});
      if (qb) t.rem = t.rem - {1'b0, t.den};
      t.quo = {t.quo[Q_W-2:0], qb};
    end
    return t;
  endfunction

  always_comb begin
    st_in.rem  = {1'b0, num};
    st_in.den  = den;
    st_in.quo  = '0;
    st_in.zero = (den == '0);
    for (int s = 0; s < DIV_STAGES; s++) begin
      st_nxt[s] = div_steps((s == 0) ? st_in : st_r[(s == 0) ? 0 : s-1], s == 0);
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_STAGES; s++) st_r[s] <= st_nxt[s];
  end

  assign q = st_r[DIV_STAGES-1].zero ? '0 : st_r[DIV_STAGES-1].quo;

endmodule

// File: rtl/activity_sequence_causal_scores.sv
// top level of the activity sequence overlap and causal score pipeline
// throughput: one transfer per cycle while rst_n is high, set by the fully pipelined four-stage dividers
// reset: synchronous active-low rst_n clears the valid chain; busy is high only during reset
// the receiver cannot stall, so results leave on out_valid without back-pressure
module activity_sequence_causal_scores #(
  parameter int SEQ_BITS = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  acs_pkg::vec_t in_seq_a,
  input  acs_pkg::vec_t in_seq_b,
  input  acs_pkg::len_t in_seq_len,
  output logic          out_valid,
  output acs_pkg::q_t   out_overlap_score,
  output acs_pkg::q_t   out_lagged_fwd,
  output acs_pkg::q_t   out_lagged_bwd,
  output acs_pkg::q_t   out_response_fwd,
  output acs_pkg::q_t   out_response_bwd,
  output acs_pkg::q_t   out_excitation_fwd,
  output acs_pkg::q_t   out_excitation_bwd
);
  import acs_pkg::*;

  // valid bit for each register stage, travels alongside the payload
  logic [LAT-1:0] vld_r, vld_nxt;

  // stage 1: masked vectors
  vec_arr_t vec_r;
  len_t     len_r;
  // stages 2 and 3: counts, length follows in step
  cnt_arr_t cnt_r;
  len_t     len_d1_r, len_d2_r;
  // stage 4: dividend and divisor per lane
  div_arr_t num_r, num_nxt, den_r, den_nxt;
  // stages 5 to 8: divider results
  q_arr_t   q;
  // stage 9: result registers
  q_t ovl_r, lag_f_r, lag_b_r, rsp_f_r, rsp_b_r, exc_f_r, exc_b_r;
  q_t ovl_nxt, lag_f_nxt, lag_b_nxt, rsp_f_nxt, rsp_b_nxt, exc_f_nxt, exc_b_nxt;

  len_t n_m1;

  // the pipeline never blocks, only reset holds transfers off
  assign busy = ~rst_n;

  acs_features #(
    .SEQ_BITS (SEQ_BITS)
  ) u_feat (
    .clk     (clk),
    .seq_a   (in_seq_a),
    .seq_b   (in_seq_b),
    .seq_len (in_seq_len),
    .vec_r   (vec_r),
    .len_r   (len_r)
  );

  acs_popcnt u_pop (
    .clk   (clk),
    .vec   (vec_r),
    .cnt_r (cnt_r)
  );

  always_ff @(posedge clk) begin
    len_d1_r <= len_r;
    len_d2_r <= len_d1_r;
  end

  // operand forming: idle-slot count is (n-1) minus the active count,
  // excitation weights 6/3/2 against 11 per active source slot
  always_comb begin
    n_m1 = (len_d2_r == '0) ? '0 : len_t'(len_d2_r - 1'b1);

    num_nxt[D_OVL]    = DIV_W'(cnt_r[V_BOTH]);
    den_nxt[D_OVL]    = DIV_W'(cnt_r[V_EITHER]);

    num_nxt[D_LAGA_F] = DIV_W'(cnt_r[V_AHIT_F]);
    den_nxt[D_LAGA_F] = DIV_W'(cnt_r[V_ACT_F]);
    num_nxt[D_LAGI_F] = DIV_W'(cnt_r[V_IHIT_F]);
    den_nxt[D_LAGI_F] = DIV_W'(n_m1) - DIV_W'(cnt_r[V_ACT_F]);

    num_nxt[D_LAGA_B] = DIV_W'(cnt_r[V_AHIT_B]);
    den_nxt[D_LAGA_B] = DIV_W'(cnt_r[V_ACT_B]);
    num_nxt[D_LAGI_B] = DIV_W'(cnt_r[V_IHIT_B]);
    den_nxt[D_LAGI_B] = DIV_W'(n_m1) - DIV_W'(cnt_r[V_ACT_B]);

    num_nxt[D_RESP_F] = DIV_W'(cnt_r[V_RESP_F]);
    den_nxt[D_RESP_F] = DIV_W'(cnt_r[V_EDGE_F]);
    num_nxt[D_RESP_B] = DIV_W'(cnt_r[V_RESP_B]);
    den_nxt[D_RESP_B] = DIV_W'(cnt_r[V_EDGE_B]);

    // baseline activity of each target over the valid length
    num_nxt[D_BASE_A] = DIV_W'(cnt_r[V_ONES_A]);
    den_nxt[D_BASE_A] = DIV_W'(len_d2_r);
    num_nxt[D_BASE_B] = DIV_W'(cnt_r[V_ONES_B]);
    den_nxt[D_BASE_B] = DIV_W'(len_d2_r);

    // lag-one hits double as the first excitation tap
    num_nxt[D_EXC_F]  = DIV_W'(6) * DIV_W'(cnt_r[V_AHIT_F])
                      + DIV_W'(3) * DIV_W'(cnt_r[V_C2_F])
                      + DIV_W'(2) * DIV_W'(cnt_r[V_C3_F]);
    den_nxt[D_EXC_F]  = DIV_W'(11) * DIV_W'(cnt_r[V_ONES_A]);
    num_nxt[D_EXC_B]  = DIV_W'(6) * DIV_W'(cnt_r[V_AHIT_B])
                      + DIV_W'(3) * DIV_W'(cnt_r[V_C2_B])
                      + DIV_W'(2) * DIV_W'(cnt_r[V_C3_B]);
    den_nxt[D_EXC_B]  = DIV_W'(11) * DIV_W'(cnt_r[V_ONES_B]);
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
  end

  for (genvar g = 0; g < NUM_DIV; g++) begin : g_div
    acs_div u_div (
      .clk (clk),
      .num (num_r[g]),
      .den (den_r[g]),
      .q   (q[g])
    );
  end

  // final combine: an empty denominator already gives zero from its lane,
  // which covers the short-length and no-edge cases
  always_comb begin
    ovl_nxt   = q[D_OVL];
    lag_f_nxt = sat_sub(q[D_LAGA_F], q[D_LAGI_F]);
    lag_b_nxt = sat_sub(q[D_LAGA_B], q[D_LAGI_B]);
    rsp_f_nxt = sat_sub(q[D_RESP_F], q[D_BASE_B]);
    rsp_b_nxt = sat_sub(q[D_RESP_B], q[D_BASE_A]);
    exc_f_nxt = (q[D_EXC_F] > ONE_Q15) ? ONE_Q15 : q[D_EXC_F];
    exc_b_nxt = (q[D_EXC_B] > ONE_Q15) ? ONE_Q15 : q[D_EXC_B];
  end

  always_ff @(posedge clk) begin
    ovl_r   <= ovl_nxt;
    lag_f_r <= lag_f_nxt;
    lag_b_r <= lag_b_nxt;
    rsp_f_r <= rsp_f_nxt;
    rsp_b_r <= rsp_b_nxt;
    exc_f_r <= exc_f_nxt;
    exc_b_r <= exc_b_nxt;
  end

  // valid chain, one bit per stage
  assign vld_nxt = {vld_r[LAT-2:0], start & ~busy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign out_valid          = vld_r[LAT-1];
  assign out_overlap_score  = ovl_r;
  assign out_lagged_fwd     = lag_f_r;
  assign out_lagged_bwd     = lag_b_r;
  assign out_response_fwd   = rsp_f_r;
  assign out_response_bwd   = rsp_b_r;
  assign out_excitation_fwd = exc_f_r;
  assign out_excitation_bwd = exc_b_r;

endmodule

// File: rtl/acs_checker.sv
// port-level checker for the score pipeline, bound to the top level
module acs_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input acs_pkg::vec_t in_seq_a,
  input acs_pkg::vec_t in_seq_b,
  input acs_pkg::len_t in_seq_len,
  input logic          out_valid,
  input acs_pkg::q_t   out_overlap_score,
  input acs_pkg::q_t   out_lagged_fwd,
  input acs_pkg::q_t   out_lagged_bwd,
  input acs_pkg::q_t   out_response_fwd,
  input acs_pkg::q_t   out_response_bwd,
  input acs_pkg::q_t   out_excitation_fwd,
  input acs_pkg::q_t   out_excitation_bwd
);
  import acs_pkg::*;

  // every transfer in gives a result a fixed latency later
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("accepted item produced no result");

  // no result appears without a matching transfer in
  a_out_from_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without an accepted item");

  // an accepted item carries known fields
  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> !$isunknown({in_seq_a, in_seq_b, in_seq_len}))
    else $error("accepted item with unknown fields");

  // all scores stay within one in Q1.15
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_overlap_score <= ONE_Q15) && (out_lagged_fwd <= ONE_Q15)
      && (out_lagged_bwd <= ONE_Q15) && (out_response_fwd <= ONE_Q15)
      && (out_response_bwd <= ONE_Q15) && (out_excitation_fwd <= ONE_Q15)
      && (out_excitation_bwd <= ONE_Q15))
    else $error("score out of range");

endmodule

bind activity_sequence_causal_scores acs_checker u_acs_checker (.*);
